// ===== hdl/rskt_pkg.sv =====
// Package with constants and types shared by the recency-sorted table.
package rskt_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  typedef enum logic [1:0] {
    ActRecord = 2'd0,
    ActDedup  = 2'd1,
    ActRead   = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] timestamp;
    logic [3:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  entry_count;
    logic        changed;
    logic        entry_valid;
    logic [31:0] entry_key;
    logic [31:0] entry_time;
    logic [31:0] entry_sequence;
  } rsp_t;

  // Ordering of rows: newer time first, higher sequence breaks ties.
  function automatic logic goes_before(logic [31:0] ta, logic [31:0] sa,
                                       logic [31:0] tb, logic [31:0] sb);
    if (ta != tb) return ta > tb;
    return sa > sb;
  endfunction
endpackage

// ===== hdl/rskt_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface rskt_req_if import rskt_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rskt_rsp_if import rskt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/recency_sorted_keyed_table.sv =====
// A read goes straight to the done state; a record walks the rows (key lookup unless
// repeats are on, then insertion sort). A deduplicate sorts the rows, then keeps the
// first row of each key; the sequencer steps one row per cycle.
// One transfer is in flight at a time; the next is taken once the result is taken.
// Reset clears the count, the sequence counter and the mode bit; row storage is not cleared.
module recency_sorted_keyed_table import rskt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rskt_req_if.sink    req,
  rskt_rsp_if.source  rsp
);
  logic allow_repeats;

  rskt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .allow_repeats_o(allow_repeats)
  );

  rskt_core u_core (
    .clk_i, .rst_ni, .allow_repeats_i(allow_repeats), .req(req), .rsp(rsp)
  );
endmodule

// ===== hdl/rskt_core.sv =====
// Sequencer that walks the row memory one row per cycle, with one ordering comparator for the sort.
module rskt_core import rskt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic allow_repeats_i,
  rskt_req_if.sink   req,
  rskt_rsp_if.source rsp
);
  typedef enum logic [3:0] {
    StIdle, StFind, StWrite, StSortOuter, StSortCmp, StSortPlace,
    StDupOuter, StDupScan, StDupCopy, StDone
  } state_e;

  logic [31:0] key_mem [Entries];
  logic [31:0] time_mem [Entries];
  logic [31:0] seq_mem [Entries];

  state_e      state_q;
  req_t        req_q;
  logic [CntW-1:0] count_q, i_q, j_q, out_q;
  logic [31:0] seqc_q;
  logic [31:0] hk_q, ht_q, hs_q;
  logic        changed_q;
  logic        sort_then_dup_q;
  rsp_t        rsp_q;
  logic        rsp_valid_q;

  // Single ordering compare unit, used by the insertion-sort phases.
  logic [IdxW-1:0] jm1;
  logic            before_prev;
  assign jm1 = IdxW'(j_q - 1'b1);
  assign before_prev = goes_before(ht_q, hs_q, time_mem[jm1], seq_mem[jm1]);

  assign req.ready = (state_q == StIdle) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StWrite) begin
      key_mem[IdxW'(i_q)] <= req_q.key;
      time_mem[IdxW'(i_q)] <= req_q.timestamp;
      // The row takes the counter value after the increment.
      seq_mem[IdxW'(i_q)] <= seqc_q + 32'd1;
    end else if (state_q == StSortCmp && j_q != '0 && before_prev) begin
      key_mem[IdxW'(j_q)] <= key_mem[jm1];
      time_mem[IdxW'(j_q)] <= time_mem[jm1];
      seq_mem[IdxW'(j_q)] <= seq_mem[jm1];
    end else if (state_q == StSortPlace) begin
      key_mem[IdxW'(j_q)] <= hk_q;
      time_mem[IdxW'(j_q)] <= ht_q;
      seq_mem[IdxW'(j_q)] <= hs_q;
    end else if (state_q == StDupCopy && out_q != i_q) begin
      key_mem[IdxW'(out_q)] <= key_mem[IdxW'(i_q)];
      time_mem[IdxW'(out_q)] <= time_mem[IdxW'(i_q)];
      seq_mem[IdxW'(out_q)] <= seq_mem[IdxW'(i_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      seqc_q <= '0;
      rsp_valid_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      out_q <= '0;
      changed_q <= 1'b0;
      sort_then_dup_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (req.valid && req.ready) begin
            req_q <= req.payload;
            unique case (action_e'(req.payload.action))
              ActRecord: begin
                changed_q <= 1'b1;
                state_q <= allow_repeats_i ? StWrite : StFind;
                // Slot for a new row: append or overwrite the last one.
                if (!allow_repeats_i) i_q <= '0;
                else if (count_q < CntW'(Entries)) i_q <= count_q;
                else i_q <= CntW'(Entries - 1);
              end
              ActDedup: begin
                changed_q <= 1'b0;
                sort_then_dup_q <= 1'b1;
                i_q <= CntW'(1);
                state_q <= StSortOuter;
              end
              default: begin
                changed_q <= 1'b0;
                i_q <= '0;
                state_q <= StDone;
              end
            endcase
          end
        end
        StFind: begin
          if (i_q >= count_q) begin
            i_q <= (count_q < CntW'(Entries)) ? count_q : CntW'(Entries - 1);
            state_q <= StWrite;
          end else if (key_mem[IdxW'(i_q)] == req_q.key) begin
            state_q <= StWrite;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        StWrite: begin
          seqc_q <= seqc_q + 32'd1;
          if (i_q == count_q) count_q <= count_q + 1'b1;
          sort_then_dup_q <= 1'b0;
          i_q <= CntW'(1);
          state_q <= StSortOuter;
        end
        StSortOuter: begin
          if (i_q >= count_q) begin
            if (sort_then_dup_q) begin
              i_q <= '0;
              out_q <= '0;
              state_q <= StDupOuter;
            end else begin
              state_q <= StDone;
            end
          end else begin
            hk_q <= key_mem[IdxW'(i_q)];
            ht_q <= time_mem[IdxW'(i_q)];
            hs_q <= seq_mem[IdxW'(i_q)];
            j_q <= i_q;
            state_q <= StSortCmp;
          end
        end
        StSortCmp: begin
          if (j_q != '0 && before_prev) j_q <= j_q - 1'b1;
          else state_q <= StSortPlace;
        end
        StSortPlace: begin
          i_q <= i_q + 1'b1;
          state_q <= StSortOuter;
        end
        StDupOuter: begin
          if (i_q >= count_q) begin
            changed_q <= (out_q != count_q);
            count_q <= out_q;
            state_q <= StDone;
          end else begin
            j_q <= '0;
            state_q <= StDupScan;
          end
        end
        StDupScan: begin
          // Compare row i against each kept row in turn.
          if (j_q >= out_q) begin
            state_q <= StDupCopy;
          end else if (key_mem[IdxW'(j_q)] == key_mem[IdxW'(i_q)]) begin
            i_q <= i_q + 1'b1;
            state_q <= StDupOuter;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        StDupCopy: begin
          out_q <= out_q + 1'b1;
          i_q <= i_q + 1'b1;
          state_q <= StDupOuter;
        end
        StDone: begin
          rsp_q.entry_count <= 5'(count_q);
          rsp_q.changed <= changed_q;
          if (action_e'(req_q.action) == ActRead &&
              CntW'(req_q.read_index) < count_q) begin
            rsp_q.entry_valid <= 1'b1;
            rsp_q.entry_key <= key_mem[IdxW'(req_q.read_index)];
            rsp_q.entry_time <= time_mem[IdxW'(req_q.read_index)];
            rsp_q.entry_sequence <= seq_mem[IdxW'(req_q.read_index)];
          end else begin
            rsp_q.entry_valid <= 1'b0;
            rsp_q.entry_key <= '0;
            rsp_q.entry_time <= '0;
            rsp_q.entry_sequence <= '0;
          end
          rsp_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== hdl/rskt_cfg.sv =====
// APB register block holding the repeat mode bit.
module rskt_cfg import rskt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        allow_repeats_o
);
  logic allow_q;
  assign pready = 1'b1;
  assign allow_repeats_o = allow_q;
  assign prdata = (paddr == 1'b0) ? {31'd0, allow_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      allow_q <= pwdata[0];
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the recency-sorted keyed table: random and directed requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rskt_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  // Predicts each response from its own copy of the table and compares the results.
  class table_scoreboard;
    bit [31:0] row_key [Entries];
    bit [31:0] row_time [Entries];
    bit [31:0] row_seq [Entries];
    int unsigned rows;
    bit [31:0] seq_count;
    bit repeats_on;
    rsp_t awaited[$];
    int errors;

    function bit outranks(bit [31:0] ta, bit [31:0] sa, bit [31:0] tb_, bit [31:0] sb);
      if (ta != tb_) return ta > tb_;
      return sa > sb;
    endfunction

    function void sort_rows();
      bit [31:0] k, t, s;
      int j;
      for (int i = 1; i < rows; i++) begin
        k = row_key[i];
        t = row_time[i];
        s = row_seq[i];
        j = i;
        while (j > 0 && outranks(t, s, row_time[j-1], row_seq[j-1])) begin
          row_key[j] = row_key[j-1];
          row_time[j] = row_time[j-1];
          row_seq[j] = row_seq[j-1];
          j--;
        end
        row_key[j] = k;
        row_time[j] = t;
        row_seq[j] = s;
      end
    endfunction

    function void record_key(bit [31:0] k, bit [31:0] t);
      int slot;
      slot = -1;
      if (!repeats_on) begin
        for (int i = 0; i < rows; i++) begin
          if (row_key[i] == k) begin
            slot = i;
            break;
          end
        end
      end
      if (slot < 0) begin
        if (rows < Entries) begin
          slot = rows;
          rows++;
        end else begin
          slot = Entries - 1;
        end
      end
      seq_count++;
      row_key[slot] = k;
      row_time[slot] = t;
      row_seq[slot] = seq_count;
      sort_rows();
    endfunction

    // Keeps the newest row of each key; returns 1 when any row was dropped.
    function bit dedupe();
      int kept;
      bit seen;
      kept = 0;
      sort_rows();
      for (int i = 0; i < rows; i++) begin
        seen = 0;
        for (int j = 0; j < kept; j++) begin
          if (row_key[j] == row_key[i]) seen = 1;
        end
        if (!seen) begin
          row_key[kept] = row_key[i];
          row_time[kept] = row_time[i];
          row_seq[kept] = row_seq[i];
          kept++;
        end
      end
      if (kept != rows) begin
        rows = kept;
        return 1;
      end
      return 0;
    endfunction

    function void note(req_t r);
      rsp_t e;
      e = '0;
      case (action_e'(r.action))
        ActRecord: begin
          record_key(r.key, r.timestamp);
          e.changed = 1'b1;
        end
        ActDedup: e.changed = dedupe();
        ActRead: begin
          if (r.read_index < rows) begin
            e.entry_valid = 1'b1;
            e.entry_key = row_key[r.read_index];
            e.entry_time = row_time[r.read_index];
            e.entry_sequence = row_seq[r.read_index];
          end
        end
        default: ;
      endcase
      e.entry_count = rows[4:0];
      awaited.push_back(e);
    endfunction

    function void check(rsp_t got);
      rsp_t e;
      if (awaited.size() == 0) begin
        $error("response with nothing awaited");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
        errors++;
      end
      if (got.changed !== e.changed) begin
        $error("changed: expected %0d, got %0d", e.changed, got.changed);
        errors++;
      end
      if (got.entry_valid !== e.entry_valid) begin
        $error("entry_valid: expected %0d, got %0d", e.entry_valid, got.entry_valid);
        errors++;
      end
      if (got.entry_key !== e.entry_key) begin
        $error("entry_key: expected %h, got %h", e.entry_key, got.entry_key);
        errors++;
      end
      if (got.entry_time !== e.entry_time) begin
        $error("entry_time: expected %h, got %h", e.entry_time, got.entry_time);
        errors++;
      end
      if (got.entry_sequence !== e.entry_sequence) begin
        $error("entry_sequence: expected %h, got %h", e.entry_sequence, got.entry_sequence);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  bit steady;  // when set, neither side inserts gaps
  int unsigned quiet_cycles = 0;
  bit [31:0] key_pool [6];
  table_scoreboard sb;

  rskt_req_if req_ch ();
  rskt_rsp_if rsp_ch ();

  recency_sorted_keyed_table uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #5 clk_i = ~clk_i;

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_repeats(bit v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {31'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.repeats_on = v;
  endtask

  function req_t make_req(action_e a, bit [31:0] k, bit [31:0] t, bit [3:0] idx);
    req_t r;
    r.action = a;
    r.key = k;
    r.timestamp = t;
    r.read_index = idx;
    return r;
  endfunction

  function req_t random_req();
    int unsigned r;
    action_e a;
    bit [31:0] k, t;
    r = $urandom_range(0, 99);
    a = r < 55 ? ActRecord : r < 65 ? ActDedup : r < 95 ? ActRead : ActNone;
    k = $urandom_range(0, 9) < 7 ? key_pool[$urandom_range(0, 5)] : $urandom;
    r = $urandom_range(0, 9);
    // Narrow time ranges give plenty of ties decided by sequence number.
    if (r < 5) t = $urandom_range(0, 12);
    else if (r < 6) t = 32'hFFFF_FFFF - $urandom_range(0, 3);
    else t = $urandom;
    return make_req(a, k, t, 4'($urandom_range(0, 15)));
  endfunction

  // Response sink with random stalls.
  initial begin : rsp_sink
    int unsigned stall;
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (!steady) begin
        stall = pick_gap();
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.payload);
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    steady = 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, refresh of a present key, ties, reads in and out of range.
    write_repeats(1'b0);
    send(make_req(ActRead, 32'h0, 32'h0, 4'd0));
    send(make_req(ActRecord, 32'h5, 32'd100, 4'd0));
    send(make_req(ActRecord, 32'h0, 32'h0, 4'd0));
    send(make_req(ActRecord, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    send(make_req(ActRecord, 32'h5, 32'd100, 4'd0));
    send(make_req(ActRecord, 32'h7, 32'd100, 4'd0));
    for (int i = 0; i < 5; i++) send(make_req(ActRead, 32'h0, 32'h0, i[3:0]));
    send(make_req(ActRead, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    send(make_req(ActDedup, 32'h0, 32'h0, 4'd0));
    send(make_req(ActNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    drain();
    write_repeats(1'b1);
    send(make_req(ActRecord, 32'h5, 32'd50, 4'd0));
    send(make_req(ActRecord, 32'h5, 32'd50, 4'd0));
    send(make_req(ActRecord, 32'h7, 32'd200, 4'd0));
    send(make_req(ActDedup, 32'h0, 32'h0, 4'd0));
    for (int i = 0; i < 4; i++) send(make_req(ActRead, 32'h0, 32'h0, i[3:0]));
    send(make_req(ActDedup, 32'h0, 32'h0, 4'd0));
    drain();

    // Random phases alternate the repeat mode; the sender waits out each phase.
    for (int p = 0; p < 4; p++) begin
      write_repeats(p[0]);
      steady = (p == 2);
      for (int n = 0; n < 250; n++) send(random_req());
      drain();
    end
    steady = 1'b0;
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/rskt_pkg.sv
hdl/rskt_if.sv
hdl/rskt_core.sv
hdl/rskt_cfg.sv
hdl/recency_sorted_keyed_table.sv
tb/sv/tb.sv
